/* rtl/itp_pkg.sv */
// itp_pkg: shared types, character codes and calendar tables for the ISO 8601
// timestamp parser. Used by itp_conv and iso8601_timestamp_parser_unit.
`timescale 1ns / 1ps

package itp_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam int unsigned FRACTION_DIGITS = 9;
	localparam logic [4:0] POS_SEC_END  = 5'd19;
	localparam logic [4:0] POS_FRAC_END = 5'(20 + FRACTION_DIGITS);
	localparam logic [4:0] POS_MAX      = 5'd31;

	// floor(x / 25) = (x * RECIP25) >> 20 for x below 8192
	localparam logic [15:0] RECIP25 = 16'd41944;
	// 1970-03-01 based day offset plus the 400-year bias, minus one for day-of-month
	localparam logic [24:0] DAY_OFS = 25'd865566;
	// Horner steps: hour, minute, second, then nine decimal steps plus one fraction add
	localparam logic [3:0] HORN_LAST = 4'd12;
	localparam logic [3:0] HORN_FRAC0 = 4'd3;

	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [29:0] frac;
		logic [3:0]  fcnt;
		logic        ok;
	} itp_fields_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// days from March 1 to the first of month m, year starting in March
	function automatic logic [8:0] march_days(input logic [3:0] m);
		logic [8:0] dd;
		case (m)
			4'd1:  dd = 9'd306;
			4'd2:  dd = 9'd337;
			4'd3:  dd = 9'd0;
			4'd4:  dd = 9'd31;
			4'd5:  dd = 9'd61;
			4'd6:  dd = 9'd92;
			4'd7:  dd = 9'd122;
			4'd8:  dd = 9'd153;
			4'd9:  dd = 9'd184;
			4'd10: dd = 9'd214;
			4'd11: dd = 9'd245;
			4'd12: dd = 9'd275;
			default: dd = 9'd0;
		endcase
		return dd;
	endfunction

endpackage

/* rtl/itp_conv.sv */
// itp_conv: date check and epoch conversion sequencer with one shared
// multiply-add unit, plus the result register. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_conv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  itp_pkg::itp_fields_t  fields,
	output logic                  busy,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  valid_res,
	output logic signed [63:0]    timestamp_ns
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LEAP = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DAYS = 3'd4;
	localparam logic [2:0] ST_HORN = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]           state_q;
	itp_pkg::itp_fields_t f_q;
	logic [7:0]           div_q;
	logic [14:0]          yadj_q;
	logic [63:0]          acc_q;
	logic                 ok_q;
	logic [3:0]           step_q;
	logic                 res_valid_q;
	logic                 valid_res_q;
	logic [63:0]          ts_q;

	// reciprocal divide by 25
	logic [12:0] rop;
	logic [28:0] rprod;
	logic [7:0]  rquo;

	// calendar check
	logic [13:0] mul100;
	logic        leap;
	logic        month_ok;
	logic        day_ok;
	logic [4:0]  mlen;
	logic [14:0] yadj;

	// day count
	logic [24:0] days;

	// shared multiply-add
	logic [6:0]  mk;
	logic [63:0] madd;
	logic [63:0] mac;

	always_comb begin
		rop = (state_q == ST_LEAP) ? {1'b0, f_q.year[13:2]} : yadj_q[14:2];
		rprod = 29'(rop) * 29'(itp_pkg::RECIP25);
		rquo = rprod[27:20];
	end

	always_comb begin
		mul100 = 14'(div_q) * 14'd100;
		leap = (f_q.year[1:0] == 2'd0) && ((mul100 != f_q.year) || (div_q[1:0] == 2'd0));
		month_ok = (f_q.month >= 7'd1) && (f_q.month <= 7'd12);
		mlen = itp_pkg::month_len(f_q.month[3:0], leap);
		day_ok = (f_q.day >= 7'd1) && (f_q.day <= {2'b00, mlen});
		yadj = 15'(f_q.year) + 15'd400 - ((f_q.month <= 7'd2) ? 15'd1 : 15'd0);
	end

	always_comb begin
		days = 25'(yadj_q) * 25'd365 + 25'(yadj_q[14:2]) - 25'(div_q) + 25'(div_q[7:2])
			+ 25'(itp_pkg::march_days(f_q.month[3:0])) + 25'(f_q.day) - itp_pkg::DAY_OFS;
	end

	always_comb begin
		case (step_q)
			4'd0: begin
				mk = 7'd24;
				madd = 64'(f_q.hour);
			end
			4'd1: begin
				mk = 7'd60;
				madd = 64'(f_q.minute);
			end
			4'd2: begin
				mk = 7'd60;
				madd = 64'(f_q.second);
			end
			default: begin
				if ((step_q - itp_pkg::HORN_FRAC0) == f_q.fcnt) begin
					mk = 7'd1;
					madd = 64'(f_q.frac);
				end else begin
					mk = 7'd10;
					madd = 64'd0;
				end
			end
		endcase
		mac = acc_q * 64'(mk) + madd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			step_q <= 4'd0;
			ok_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ok_q <= fields.ok;
						state_q <= fields.ok ? ST_LEAP : ST_OUT;
					end
				end
				ST_LEAP: state_q <= ST_CHK;
				ST_CHK: begin
					if (month_ok && day_ok) begin
						state_q <= ST_DIV;
					end else begin
						ok_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: state_q <= ST_DAYS;
				ST_DAYS: begin
					step_q <= 4'd0;
					state_q <= ST_HORN;
				end
				ST_HORN: begin
					step_q <= step_q + 4'd1;
					if (step_q == itp_pkg::HORN_LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					f_q <= fields;
					acc_q <= 64'd0;
				end
			end
			ST_LEAP: div_q <= rquo;
			ST_CHK: yadj_q <= yadj;
			ST_DIV: div_q <= rquo;
			ST_DAYS: acc_q <= {{39{days[24]}}, days};
			ST_HORN: acc_q <= mac;
			ST_OUT: begin
				if (!res_valid_q || res_ready) begin
					valid_res_q <= ok_q;
					ts_q <= ok_q ? acc_q : 64'd0;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign valid_res = valid_res_q;
	assign timestamp_ns = ts_q;

endmodule

/* rtl/iso8601_timestamp_parser_unit.sv */
// iso8601_timestamp_parser_unit: top level; per-character field parser and
// handshakes. Depends on itp_pkg and itp_conv.
`timescale 1ns / 1ps

// channel  | valid      | ready      | payload
// char     | char_valid | char_ready | char_code[7:0], last_char
// result   | res_valid  | res_ready  | valid_res, timestamp_ns[63:0] signed
//
// After the last character the conversion sequencer holds char_ready low
// on a valid date through the calendar check, the day count and 13 steps of
// the shared multiply-add, on a nonexistent date through the calendar check
// alone, and on a malformed string only through the result state, plus any
// wait for the result register to free.
// Characters of the next string are accepted while a result waits.
// Asynchronous active-low reset clears the parser and the sequencer.

module iso8601_timestamp_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               valid_res,
	output logic signed [63:0] timestamp_ns
);

	logic [4:0]  pos_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;
	logic [29:0] frac_q;
	logic [3:0]  fcnt_q;
	logic        malf_q;

	logic [4:0]  pos_n;
	logic [13:0] year_n;
	logic [6:0]  month_n, day_n, hour_n, minute_n, second_n;
	logic [29:0] frac_n;
	logic [3:0]  fcnt_n;
	logic        malf_n;

	logic        digit;
	logic [3:0]  dval;
	logic        accept;
	logic        start;
	logic        busy;
	itp_pkg::itp_fields_t fields;

	assign accept = char_valid && char_ready;
	assign start = accept && last_char;
	assign char_ready = !busy;

	always_comb begin
		digit = (char_code >= itp_pkg::CH_ZERO) && (char_code <= itp_pkg::CH_NINE);
		dval = digit ? 4'(char_code - itp_pkg::CH_ZERO) : 4'd0;
		year_n = year_q;
		month_n = month_q;
		day_n = day_q;
		hour_n = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		frac_n = frac_q;
		fcnt_n = fcnt_q;
		malf_n = malf_q;
		case (pos_q) inside
			[5'd0:5'd3]: begin
				if (digit) year_n = year_q * 14'd10 + 14'(dval); else malf_n = 1'b1;
			end
			5'd4, 5'd7: begin
				if (char_code != itp_pkg::CH_DASH) malf_n = 1'b1;
			end
			5'd5, 5'd6: begin
				if (digit) month_n = month_q * 7'd10 + 7'(dval); else malf_n = 1'b1;
			end
			5'd8, 5'd9: begin
				if (digit) day_n = day_q * 7'd10 + 7'(dval); else malf_n = 1'b1;
			end
			5'd10: begin
				if (char_code != itp_pkg::CH_T) malf_n = 1'b1;
			end
			5'd11, 5'd12: begin
				if (digit) hour_n = hour_q * 7'd10 + 7'(dval); else malf_n = 1'b1;
			end
			5'd13, 5'd16: begin
				if (char_code != itp_pkg::CH_COLON) malf_n = 1'b1;
			end
			5'd14, 5'd15: begin
				if (digit) minute_n = minute_q * 7'd10 + 7'(dval); else malf_n = 1'b1;
			end
			5'd17, 5'd18: begin
				if (digit) second_n = second_q * 7'd10 + 7'(dval); else malf_n = 1'b1;
			end
			5'd19: begin
				if (char_code != itp_pkg::CH_DOT) malf_n = 1'b1;
			end
			default: begin
				if (pos_q < itp_pkg::POS_FRAC_END && digit) begin
					frac_n = frac_q * 30'd10 + 30'(dval);
					fcnt_n = fcnt_q + 4'd1;
				end else begin
					malf_n = 1'b1;
				end
			end
		endcase
		pos_n = (pos_q == itp_pkg::POS_MAX) ? pos_q : pos_q + 5'd1;
	end

	always_comb begin
		fields.year = year_n;
		fields.month = month_n;
		fields.day = day_n;
		fields.hour = hour_n;
		fields.minute = minute_n;
		fields.second = second_n;
		fields.frac = frac_n;
		fields.fcnt = fcnt_n;
		fields.ok = !malf_n && (pos_n >= itp_pkg::POS_SEC_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
			year_q <= 14'd0;
			month_q <= 7'd0;
			day_q <= 7'd0;
			hour_q <= 7'd0;
			minute_q <= 7'd0;
			second_q <= 7'd0;
			frac_q <= 30'd0;
			fcnt_q <= 4'd0;
			malf_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				pos_q <= 5'd0;
				year_q <= 14'd0;
				month_q <= 7'd0;
				day_q <= 7'd0;
				hour_q <= 7'd0;
				minute_q <= 7'd0;
				second_q <= 7'd0;
				frac_q <= 30'd0;
				fcnt_q <= 4'd0;
				malf_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				year_q <= year_n;
				month_q <= month_n;
				day_q <= day_n;
				hour_q <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				frac_q <= frac_n;
				fcnt_q <= fcnt_n;
				malf_q <= malf_n;
			end
		end
	end

	itp_conv u_conv (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.fields       (fields),
		.busy         (busy),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.valid_res    (valid_res),
		.timestamp_ns (timestamp_ns)
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !valid_res) |-> (timestamp_ns == 64'sd0))
		else $error("invalid result with nonzero timestamp");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_ready && last_char) |=> !char_ready)
		else $error("char accepted during conversion");

	a_mid_free: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_ready && !last_char) |=> char_ready)
		else $error("conversion started without last char");

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_ready && last_char) |=> (pos_q == 5'd0 && !malf_q))
		else $error("parser state not cleared after string");

endmodule
